/* rtl/acs_pkg.sv */
// Shared opcodes, immediate kinds, widths and the memory request type of the step unit.
package acs_pkg;

	localparam int MemDepthDef = 256;
	localparam int DataW       = 8;
	localparam int PcW         = 16;
	localparam int AddrW       = 8;

	typedef enum logic [7:0] {
		OP_ADD  = 8'd0,
		OP_SUB  = 8'd1,
		OP_AND  = 8'd2,
		OP_OR   = 8'd3,
		OP_XOR  = 8'd4,
		OP_NOT  = 8'd5,
		OP_PUSH = 8'd6,
		OP_LDI  = 8'd7,
		OP_POP  = 8'd8,
		OP_LD   = 8'd9,
		OP_CMP  = 8'd10,
		OP_PPC  = 8'd11,
		OP_RET  = 8'd12,
		OP_JMP  = 8'd13,
		OP_ST   = 8'd14,
		OP_PSP  = 8'd15,
		OP_OUT  = 8'd16,
		OP_IN   = 8'd17
	} op_t;

	localparam logic [7:0] CMP_EQ = 8'd0;
	localparam logic [7:0] CMP_GT = 8'd1;
	localparam logic [7:0] CMP_GE = 8'd2;
	localparam logic [7:0] CMP_LT = 8'd3;
	localparam logic [7:0] CMP_LE = 8'd4;

	localparam logic [7:0] JMP_IF_ONE  = 8'd0;
	localparam logic [7:0] JMP_IF_ZERO = 8'd1;
	localparam logic [7:0] JMP_ALWAYS  = 8'd2;

	typedef struct packed {
		logic             rd_en;
		logic [AddrW-1:0] rd_addr_a;
		logic [AddrW-1:0] rd_addr_b;
		logic             wr_en;
		logic [AddrW-1:0] wr_addr;
		logic [DataW-1:0] wr_data;
	} ram_req_t;

endpackage

/* rtl/acs_ram.sv */
// Data memory with one write port, two registered read ports and per-entry valid bits.
module acs_ram import acs_pkg::*; #(
	parameter int MEM_DEPTH = MemDepthDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ram_req_t         req,
	output logic [DataW-1:0] rd_data_a,
	output logic [DataW-1:0] rd_data_b
);

	localparam int AW = $clog2(MEM_DEPTH);

	logic [DataW-1:0]     mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] vld_q;
	logic [DataW-1:0]     rd_a_q;
	logic [DataW-1:0]     rd_b_q;
	logic                 rd_vld_a_q;
	logic                 rd_vld_b_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_a_q <= mem_q[req.rd_addr_a[AW-1:0]];
			rd_b_q <= mem_q[req.rd_addr_b[AW-1:0]];
		end
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_vld_a_q <= 1'b0;
			rd_vld_b_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr[AW-1:0]] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_a_q <= vld_q[req.rd_addr_a[AW-1:0]];
				rd_vld_b_q <= vld_q[req.rd_addr_b[AW-1:0]];
			end
		end
	end

	assign rd_data_a = rd_vld_a_q ? rd_a_q : '0;
	assign rd_data_b = rd_vld_b_q ? rd_b_q : '0;

endmodule

/* rtl/accumulator_stack_cpu_step_unit.sv */
// Top level of the accumulator machine step unit: decode, memory access and write-back.
// Execution: an accepted word is held in the execute register until the result register
// is free or res_ready is high; its result is then registered and offered on res_valid.
// Flow: no new word is accepted while one is in execution, set by the registered reads
// of the data memory and its single write port (a two-byte push writes twice).
// Reset: accumulator, stack pointer and program counter clear to zero and the memory's
// valid bits clear at once, so every entry reads as zero; no clearing pass is needed.
module accumulator_stack_cpu_step_unit import acs_pkg::*; #(
	parameter int MEM_DEPTH = MemDepthDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       opcode,
	input  logic [7:0]       immediate,
	input  logic [7:0]       in_char,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [PcW-1:0]   next_pc,
	output logic             out_valid,
	output logic [DataW-1:0] out_byte,
	output logic [DataW-1:0] acc_value,
	output logic             error_code
);

	logic [DataW-1:0] acc_q;
	logic [AddrW-1:0] sp_q;
	logic [PcW-1:0]   pc_q;

	logic             s1_valid_q;
	logic [7:0]       op_s1;
	logic [7:0]       imm_s1;
	logic [7:0]       in_char_s1;
	logic             err_s1;
	logic             taken_s1;

	logic             res_valid_q;
	logic [PcW-1:0]   next_pc_q;
	logic             out_valid_q;
	logic [DataW-1:0] out_byte_q;
	logic [DataW-1:0] acc_value_q;
	logic             error_code_q;

	logic             accept;
	logic             complete;
	logic             dec_err;
	logic             dec_taken;
	logic [PcW-1:0]   pc_inc;
	logic             wr_early;
	logic             wr_late;
	ram_req_t         ram_req;
	logic [DataW-1:0] rd_a;
	logic [DataW-1:0] rd_b;
	logic             cmp_hit;
	logic [DataW-1:0] nxt_acc;
	logic [AddrW-1:0] nxt_sp;
	logic [PcW-1:0]   nxt_pc;

	assign in_ready = !s1_valid_q;
	assign accept   = in_valid && in_ready;
	assign complete = s1_valid_q && (!res_valid_q || res_ready);
	assign pc_inc   = pc_q + PcW'(2);

	always_comb begin
		dec_err   = 1'b0;
		dec_taken = 1'b0;
		case (opcode)
			OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_LDI, OP_LD,
			OP_PPC, OP_ST, OP_PSP, OP_OUT, OP_IN: begin
				dec_err = 1'b0;
			end
			OP_CMP: begin
				dec_err = immediate > CMP_LE;
			end
			OP_RET: begin
				dec_taken = 1'b1;
			end
			OP_JMP: begin
				dec_err   = immediate > JMP_ALWAYS;
				dec_taken = (immediate == JMP_ALWAYS)
					|| (immediate == JMP_IF_ONE && acc_q == DataW'(1))
					|| (immediate == JMP_IF_ZERO && acc_q == '0);
			end
			default: begin
				dec_err = 1'b1;
			end
		endcase
	end

	// The first byte of a two-byte push is written at the accepting edge, the second
	// byte and the store data at the completing edge; the two never coincide.
	assign wr_early = accept && !dec_err && (opcode == OP_PPC || opcode == OP_PSP);
	assign wr_late  = complete && !err_s1
		&& (op_s1 == OP_PPC || op_s1 == OP_PSP || op_s1 == OP_ST);

	always_comb begin
		ram_req.rd_en     = accept;
		ram_req.rd_addr_a = (opcode == OP_LD) ? acc_q : sp_q - AddrW'(1);
		ram_req.rd_addr_b = sp_q - AddrW'(2);
		ram_req.wr_en     = wr_early || wr_late;
		ram_req.wr_addr   = sp_q;
		ram_req.wr_data   = '0;
		if (wr_early) begin
			ram_req.wr_data = (opcode == OP_PPC) ? pc_inc[DataW-1:0] : sp_q;
		end else if (op_s1 == OP_ST) begin
			ram_req.wr_addr = acc_q;
			ram_req.wr_data = rd_a;
		end else begin
			ram_req.wr_addr = sp_q + AddrW'(1);
			ram_req.wr_data = (op_s1 == OP_PPC) ? pc_inc[PcW-1:DataW] : '0;
		end
	end

	acs_ram #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_ram (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (ram_req),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	always_comb begin
		case (imm_s1)
			CMP_EQ:  cmp_hit = acc_q == rd_a;
			CMP_GT:  cmp_hit = acc_q > rd_a;
			CMP_GE:  cmp_hit = acc_q >= rd_a;
			CMP_LT:  cmp_hit = acc_q < rd_a;
			default: cmp_hit = acc_q <= rd_a;
		endcase
	end

	always_comb begin
		nxt_acc = acc_q;
		nxt_sp  = sp_q;
		nxt_pc  = pc_inc;
		case (op_s1)
			OP_ADD: nxt_acc = acc_q + rd_a;
			OP_SUB: nxt_acc = acc_q - rd_a;
			OP_AND: nxt_acc = acc_q & rd_a;
			OP_OR:  nxt_acc = acc_q | rd_a;
			OP_XOR: nxt_acc = acc_q ^ rd_a;
			OP_NOT: nxt_acc = ~acc_q;
			OP_LDI: nxt_acc = imm_s1;
			OP_LD:  nxt_acc = rd_a;
			OP_CMP: begin
				nxt_acc = {{(DataW-1){1'b0}}, cmp_hit};
				nxt_sp  = sp_q - AddrW'(1);
			end
			OP_PPC, OP_PSP: nxt_sp = sp_q + AddrW'(2);
			OP_RET, OP_JMP: begin
				if (taken_s1) begin
					nxt_sp = sp_q - AddrW'(2);
					nxt_pc = {rd_a, rd_b};
				end
			end
			OP_ST:  nxt_sp = sp_q - AddrW'(1);
			OP_IN:  nxt_acc = in_char_s1;
			default: nxt_acc = acc_q;
		endcase
		if (err_s1) begin
			nxt_acc = acc_q;
			nxt_sp  = sp_q;
			nxt_pc  = pc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			sp_q        <= '0;
			pc_q        <= '0;
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (complete) begin
				s1_valid_q <= 1'b0;
			end
			if (complete) begin
				acc_q       <= nxt_acc;
				sp_q        <= nxt_sp;
				pc_q        <= nxt_pc;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= opcode;
			imm_s1     <= immediate;
			in_char_s1 <= in_char;
			err_s1     <= dec_err;
			taken_s1   <= dec_taken;
		end
		if (complete) begin
			next_pc_q    <= nxt_pc;
			out_valid_q  <= !err_s1 && op_s1 == OP_OUT;
			out_byte_q   <= (!err_s1 && op_s1 == OP_OUT) ? acc_q : '0;
			acc_value_q  <= nxt_acc;
			error_code_q <= err_s1;
		end
	end

	assign res_valid  = res_valid_q;
	assign next_pc    = next_pc_q;
	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign acc_value  = acc_value_q;
	assign error_code = error_code_q;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("Accepted word did not enter execution.");

	a_complete_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		complete |=> res_valid_q)
		else $error("Completed word produced no result.");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_early && wr_late))
		else $error("Two memory writes requested in one cycle.");

	a_error_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		complete && err_s1 |=> $stable(acc_q) && $stable(sp_q) && $stable(pc_q))
		else $error("Erroring word changed machine state.");

endmodule
